// ===== hw/rtl/dtbd_pkg.sv =====
// Package with the shared types and constants of the digit text to byte decoder.
`default_nettype none

package dtbd_pkg;

   // Radix mode register codes. Codes 6 and 7 behave like the none mode.
   typedef enum logic [2:0] {
      MODE_ASCII   = 3'd0,
      MODE_HEX     = 3'd1,
      MODE_DECIMAL = 3'd2,
      MODE_OCTAL   = 3'd3,
      MODE_BINARY  = 3'd4,
      MODE_NONE    = 3'd5
   } radix_mode_type;

   // Why a byte was closed.
   typedef enum logic [1:0] {
      STOP_WIDTH    = 2'd0,
      STOP_INVALID  = 2'd1,
      STOP_OVERFLOW = 2'd2,
      STOP_FLUSH    = 2'd3
   } stop_reason_type;

   // One result beat as held in the output buffer.
   typedef struct packed {
      logic [7:0]      value;
      logic [3:0]      digits_used;
      logic            char_consumed;
      stop_reason_type stop_reason;
   } rsp_beat_type;

   localparam radix_mode_type RESET_MODE = MODE_HEX;

   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_ONE     = 8'h31;
   localparam logic [7:0] CHAR_SEVEN   = 8'h37;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;

   // Digits per byte in each digit mode.
   localparam logic [3:0] WIDTH_HEX     = 4'd2;
   localparam logic [3:0] WIDTH_DECIMAL = 4'd3;
   localparam logic [3:0] WIDTH_OCTAL   = 4'd3;
   localparam logic [3:0] WIDTH_BINARY  = 4'd8;

endpackage : dtbd_pkg

`default_nettype wire

// ===== hw/rtl/dtbd_req_if.sv =====
// Valid/ready channel interfaces for character beats and result beats.
`default_nettype none

interface dtbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       flush;

   modport source (output valid, output ch, output flush, input ready);
   modport sink   (input valid, input ch, input flush, output ready);
endinterface : dtbd_req_if

interface dtbd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] value;
   logic [3:0] digits_used;
   logic       char_consumed;
   logic [1:0] stop_reason;

   modport source (output valid, output value, output digits_used,
                   output char_consumed, output stop_reason, input ready);
   modport sink   (input valid, input value, input digits_used,
                   input char_consumed, input stop_reason, output ready);
endinterface : dtbd_rsp_if

`default_nettype wire

// ===== hw/rtl/digit_text_to_byte_decoder_unit.sv =====
// Top level of the digit text to byte decoder: decode logic and output buffer.
//
// Usage: characters enter as beats on req_chan (ch plus a flush flag). Each
// accepted beat is decoded in the cycle it is accepted against the held
// accumulator and digit count, and produces zero or one result beat on
// rsp_chan (value, digits_used, char_consumed, stop_reason).
// The radix mode is written through csr_we / csr_wdata; the user must do so only
// while the block is idle, which the block does not enforce. A write also drops
// any pending digits without producing a result. A result beat is registered in
// the output buffer before it shows on rsp_chan. Throughput: one character beat
// per cycle while req_chan.ready is high. The accumulator and digit count are
// updated in the accept cycle, so the next character sees them at once.
// Output buffer: a two-entry buffer (head plus skid register) sits in front
// of rsp_chan. req_chan.ready depends only on the skid register, so a new
// beat is accepted while a finished result still waits at the head. When the
// receiver stalls, the head holds, the next result lands in the skid
// register, and only then does req_chan.ready drop.
// A character that is not consumed is not replayed; the sender presents it again.
// Reset: synchronous and active high. It sets hex mode, clears the
// accumulator and count, and empties the output buffer.
`default_nettype none

module digit_text_to_byte_decoder_unit
   import dtbd_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  wire        csr_we,
   input  wire [2:0]  csr_wdata,
   dtbd_req_if.sink   req_chan,
   dtbd_rsp_if.source rsp_chan
);

   // Configuration and decode state.
   radix_mode_type mode_ff;
   logic [7:0]     acc_ff, acc_in;
   logic [2:0]     cnt_ff, cnt_in;

   // Output buffer: head drives the result channel, skid catches overflow.
   rsp_beat_type   head_ff, head_in;
   rsp_beat_type   skid_ff, skid_in;
   logic           head_valid_ff, head_valid_in;
   logic           skid_valid_ff, skid_valid_in;

   logic           accept;
   logic           pop;
   logic           push;

   // Decode signals.
   logic           is_dec;
   logic           is_upper;
   logic           is_lower;
   logic [3:0]     dec_val;
   logic [3:0]     digit;
   logic           digit_ok;
   logic           digit_mode;
   logic [11:0]    scaled;
   logic [11:0]    sum;
   logic           overflow;
   logic [3:0]     count_inc;
   logic [3:0]     width;
   logic           has_result;
   rsp_beat_type   result;

   assign req_chan.ready = !skid_valid_ff;
   assign accept         = req_chan.valid && req_chan.ready;
   assign pop            = head_valid_ff && rsp_chan.ready;
   assign push           = accept && has_result;

   assign rsp_chan.valid         = head_valid_ff;
   assign rsp_chan.value         = head_ff.value;
   assign rsp_chan.digits_used   = head_ff.digits_used;
   assign rsp_chan.char_consumed = head_ff.char_consumed;
   assign rsp_chan.stop_reason   = head_ff.stop_reason;

   // Character classification.
   always_comb begin
      is_dec   = (req_chan.ch >= CHAR_ZERO) && (req_chan.ch <= CHAR_NINE);
      is_upper = (req_chan.ch >= CHAR_UPPER_A) && (req_chan.ch <= CHAR_UPPER_F);
      is_lower = (req_chan.ch >= CHAR_LOWER_A) && (req_chan.ch <= CHAR_LOWER_F);
      dec_val  = req_chan.ch[3:0];
   end

   // Per-mode digit check, scaled accumulator and digit width. The scaling
   // is a shift, or shift-and-add for decimal.
   always_comb begin
      digit      = dec_val;
      digit_ok   = 1'b0;
      digit_mode = 1'b1;
      scaled     = 12'd0;
      width      = WIDTH_HEX;
      unique case (mode_ff)
         MODE_HEX: begin
            digit_ok = is_dec || is_upper || is_lower;
            if (is_upper || is_lower) begin
               digit = req_chan.ch[3:0] + 4'd9;
            end
            scaled = {acc_ff, 4'b0000};
            width  = WIDTH_HEX;
         end
         MODE_DECIMAL: begin
            digit_ok = is_dec;
            scaled   = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0};
            width    = WIDTH_DECIMAL;
         end
         MODE_OCTAL: begin
            digit_ok = (req_chan.ch >= CHAR_ZERO) && (req_chan.ch <= CHAR_SEVEN);
            scaled   = {1'b0, acc_ff, 3'b000};
            width    = WIDTH_OCTAL;
         end
         MODE_BINARY: begin
            digit_ok = (req_chan.ch == CHAR_ZERO) || (req_chan.ch == CHAR_ONE);
            scaled   = {3'b000, acc_ff, 1'b0};
            width    = WIDTH_BINARY;
         end
         default: begin
            digit_mode = 1'b0;
         end
      endcase
      sum       = scaled + {8'd0, digit};
      overflow  = (sum[11:8] != 4'd0);
      count_inc = {1'b0, cnt_ff} + 4'd1;
   end

   // Decision for one accepted beat: result fields and next decode state.
   always_comb begin
      acc_in     = acc_ff;
      cnt_in     = cnt_ff;
      has_result = 1'b0;
      result     = '{value: acc_ff, digits_used: {1'b0, cnt_ff},
                     char_consumed: 1'b0, stop_reason: STOP_FLUSH};
      priority if (req_chan.flush) begin
         // Flush closes a pending value; with nothing pending it is silent.
         if (cnt_ff != 3'd0) begin
            has_result = 1'b1;
            acc_in     = 8'd0;
            cnt_in     = 3'd0;
         end
      end else if (mode_ff == MODE_ASCII) begin
         // Raw mode: the character itself is the byte.
         has_result = 1'b1;
         result     = '{value: req_chan.ch, digits_used: 4'd1,
                        char_consumed: 1'b1, stop_reason: STOP_WIDTH};
      end else if (!digit_mode) begin
         // None mode and unused codes reject every character.
         has_result = 1'b1;
         result     = '{value: 8'd0, digits_used: 4'd0,
                        char_consumed: 1'b0, stop_reason: STOP_INVALID};
      end else if (!digit_ok) begin
         has_result         = 1'b1;
         result.stop_reason = STOP_INVALID;
         acc_in             = 8'd0;
         cnt_in             = 3'd0;
      end else if (overflow) begin
         has_result         = 1'b1;
         result.stop_reason = STOP_OVERFLOW;
         acc_in             = 8'd0;
         cnt_in             = 3'd0;
      end else if (count_inc >= width) begin
         has_result = 1'b1;
         result     = '{value: sum[7:0], digits_used: count_inc,
                        char_consumed: 1'b1, stop_reason: STOP_WIDTH};
         acc_in     = 8'd0;
         cnt_in     = 3'd0;
      end else begin
         acc_in = sum[7:0];
         cnt_in = count_inc[2:0];
      end
   end

   // Output buffer next state. The skid register is only filled when the
   // head stays occupied; it drains into the head on the next pop.
   always_comb begin
      head_in       = head_ff;
      skid_in       = skid_ff;
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            head_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!head_valid_ff || pop) begin
            head_in       = result;
            head_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         head_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= RESET_MODE;
         acc_ff        <= 8'd0;
         cnt_ff        <= 3'd0;
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            mode_ff <= radix_mode_type'(csr_wdata);
            acc_ff  <= 8'd0;
            cnt_ff  <= 3'd0;
         end else if (accept) begin
            acc_ff <= acc_in;
            cnt_ff <= cnt_in;
         end
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

endmodule : digit_text_to_byte_decoder_unit

`default_nettype wire

// ===== hw/rtl/dtbd_checker.sv =====
// Port-level checker for the digit text to byte decoder, bound to the top level.
`default_nettype none

module dtbd_checker
   import dtbd_pkg::*;
(
   input wire       clock,
   input wire       reset,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire [7:0] rsp_value,
   input wire [3:0] rsp_digits_used,
   input wire       rsp_char_consumed,
   input wire [1:0] rsp_stop_reason
);

   // A stalled result beat keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) &&
      $stable(rsp_digits_used) && $stable(rsp_char_consumed) &&
      $stable(rsp_stop_reason))
   else $error("result beat changed while stalled");

   // Reset empties the output buffer.
   assert property (@(posedge clock) reset |=> !rsp_valid)
   else $error("result beat present after reset");

   // Only a completed width consumes the closing character.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_char_consumed |->
      rsp_stop_reason == STOP_WIDTH && rsp_digits_used != 4'd0)
   else $error("consumed character with a non-width stop");

   // A flush result always carries pending digits and no character.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stop_reason == STOP_FLUSH |->
      rsp_digits_used != 4'd0 && !rsp_char_consumed)
   else $error("flush result without pending digits");

endmodule : dtbd_checker

bind digit_text_to_byte_decoder_unit dtbd_checker u_dtbd_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_value         (rsp_chan.value),
   .rsp_digits_used   (rsp_chan.digits_used),
   .rsp_char_consumed (rsp_chan.char_consumed),
   .rsp_stop_reason   (rsp_chan.stop_reason)
);

`default_nettype wire
